### rtl/cfd_pkg.sv
// Shared types and constants for the complex decimating FIR filter.
// No dependencies; every other file of the block but cfd_stream_if imports this package.
package cfd_pkg;

   // sample and coefficient format: Q1.15
   localparam int SAMPLE_BITS = 16;
   localparam int FRAC_BITS   = SAMPLE_BITS - 1;

   // configuration port
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 9;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DECIMATION  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TAPS_IN_USE = 2'd1;

   // request function codes
   localparam logic FUNC_SAMPLE    = 1'b0;
   localparam logic FUNC_TAP_WRITE = 1'b1;

   typedef struct packed {
      logic                          func;
      logic signed [SAMPLE_BITS-1:0] sample_i;
      logic signed [SAMPLE_BITS-1:0] sample_q;
      logic [5:0]                    tap_index;
      logic signed [SAMPLE_BITS-1:0] tap_value;
   } req_payload_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] out_i;
      logic signed [SAMPLE_BITS-1:0] out_q;
      logic                          saturated;
   } rsp_payload_type;

   typedef struct packed {
      logic [CSR_INDEX_BITS-1:0] index;
      logic [CSR_DATA_BITS-1:0]  data;
   } csr_payload_type;

   // one complex history entry
   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] i;
      logic signed [SAMPLE_BITS-1:0] q;
   } sample_type;

   // controls shared by every cell of the row
   typedef struct packed {
      logic shift_hist;
      logic load_taps;
      logic shift_taps;
   } cell_ctl_type;

   // controls of the multiply-accumulate unit
   typedef struct packed {
      logic clear;
      logic gate;
   } mac_ctl_type;

endpackage

### rtl/cfd_stream_if.sv
// Valid/ready channel used for requests, results and configuration writes.
// Payload type is given at instantiation; no other dependencies.
interface cfd_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### rtl/complex_decimating_fir_top.sv
// Complex decimating FIR filter: top level with sequencer and cell row.
// Depends on cfd_pkg, cfd_stream_if, cfd_cell and cfd_mac.
//
// Usage:
//   req_ch carries one request: a complex Q1.15 sample (func 0) or one
//   coefficient write (func 1). rsp_ch returns one filtered I/Q pair with a
//   saturation flag. csr_ch writes decimation (index 0) and taps_in_use
//   (index 1); it is always ready and should be written while idle.
//   A coefficient write, or a sample that yields no output, is taken in
//   the idle state and leaves the block idle. A sample that yields an
//   output rotates the history ring of MAX_TAPS cells once, the whole ring
//   whatever taps_in_use is, past a single complex multiply-accumulate
//   unit, then passes a drain state and a done state; no request is taken
//   until it is back in idle. The result waits in an output register, so
//   requests are still taken while rsp_ch is stalled; only a second output
//   stalls in its done state until the first has gone.
//   Synchronous reset clears history, coefficients, fill count and phase
//   and sets both configuration registers to 1.
module complex_decimating_fir_top #(
   parameter int MAX_TAPS = 64,
   parameter int ACC_BITS = 40
) (
   input logic         clock,
   input logic         reset,
   cfd_stream_if.sink   req_ch,
   cfd_stream_if.source rsp_ch,
   cfd_stream_if.sink   csr_ch
);
   import cfd_pkg::*;

   localparam int NW = $clog2(MAX_TAPS + 1);
   localparam int SW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int TW = (NW > 7) ? NW : 7;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   state_type       state_ff, state_in;
   logic [SW-1:0]   step_ff, step_in;
   logic [NW-1:0]   fill_ff, fill_in, fill_inc;
   logic [7:0]      phase_ff, phase_in;
   logic [8:0]      dec_ff, dec_in;
   logic [NW-1:0]   taps_ff, taps_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic            req_fire, sample_fire, tap_fire, csr_fire;
   logic            window_full, emit, gate, step_last;
   logic [8:0]      phase_inc;
   logic [TW-1:0]   taps_req;
   cell_ctl_type    cell_ctl;
   mac_ctl_type     mac_ctl;
   rsp_payload_type mac_result;
   sample_type      head_in;

   sample_type                    hist [MAX_TAPS];
   logic signed [SAMPLE_BITS-1:0] tapw [MAX_TAPS];

   // handshakes
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign sample_fire  = req_fire && (req_ch.payload.func == FUNC_SAMPLE);
   assign tap_fire     = req_fire && (req_ch.payload.func == FUNC_TAP_WRITE);
   assign csr_fire     = csr_ch.valid && csr_ch.ready;

   // window and decimation bookkeeping
   assign fill_inc    = (fill_ff < NW'(MAX_TAPS)) ? fill_ff + NW'(1) : fill_ff;
   assign window_full = (fill_inc >= taps_ff);
   assign emit        = sample_fire && window_full && (phase_ff == 8'd0);
   assign phase_inc   = {1'b0, phase_ff} + 9'd1;

   // tap k meets the history entry n-1-k on the last n steps of the ring
   assign gate      = (state_ff == ST_RUN) && (NW'(step_ff) >= NW'(MAX_TAPS) - taps_ff);
   assign step_last = (step_ff == SW'(MAX_TAPS - 1));

   assign cell_ctl.shift_hist = sample_fire || (state_ff == ST_RUN);
   assign cell_ctl.load_taps  = emit;
   assign cell_ctl.shift_taps = gate;
   assign mac_ctl.clear       = emit;
   assign mac_ctl.gate        = gate;

   // head of the ring: new sample on a request, else the tail wraps round
   always_comb begin
      if (sample_fire) begin
         head_in.i = req_ch.payload.sample_i;
         head_in.q = req_ch.payload.sample_q;
      end else begin
         head_in = hist[MAX_TAPS-1];
      end
   end

   // row of cells
   for (genvar j = 0; j < MAX_TAPS; j++) begin : g_cell
      sample_type                    cell_hist_in;
      logic signed [SAMPLE_BITS-1:0] cell_tapw_in;
      logic                          cell_tap_wr;

      if (j == 0) begin : g_head
         assign cell_hist_in = head_in;
      end else begin : g_body
         assign cell_hist_in = hist[j-1];
      end
      if (j == MAX_TAPS - 1) begin : g_tail
         assign cell_tapw_in = '0;
      end else begin : g_inner
         assign cell_tapw_in = tapw[j+1];
      end
      assign cell_tap_wr = tap_fire && (32'(req_ch.payload.tap_index) == j);

      cfd_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (cell_ctl),
         .tap_wr    (cell_tap_wr),
         .tap_wdata (req_ch.payload.tap_value),
         .hist_in   (cell_hist_in),
         .tapw_in   (cell_tapw_in),
         .hist_out  (hist[j]),
         .tapw_out  (tapw[j])
      );
   end

   cfd_mac #(.ACC_BITS(ACC_BITS)) u_mac (
      .clock  (clock),
      .ctl    (mac_ctl),
      .tap    (tapw[0]),
      .smp    (hist[MAX_TAPS-1]),
      .result (mac_result)
   );

   // next state, counters, configuration and output register
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      fill_in      = fill_ff;
      phase_in     = phase_ff;
      dec_in       = dec_ff;
      taps_in      = taps_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in  = rsp_data_ff;
      taps_req     = TW'(csr_ch.payload.data[6:0]);

      if (csr_fire) begin
         case (csr_ch.payload.index)
            CSR_DECIMATION: begin
               if (csr_ch.payload.data == 9'd0) begin
                  dec_in = 9'd1;
               end else if (csr_ch.payload.data > 9'd256) begin
                  dec_in = 9'd256;
               end else begin
                  dec_in = csr_ch.payload.data;
               end
            end
            CSR_TAPS_IN_USE: begin
               if (taps_req == '0) begin
                  taps_in = NW'(1);
               end else if (taps_req > TW'(MAX_TAPS)) begin
                  taps_in = NW'(MAX_TAPS);
               end else begin
                  taps_in = NW'(taps_req);
               end
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (sample_fire) begin
               fill_in = fill_inc;
               if (window_full) begin
                  phase_in = (phase_inc >= dec_ff) ? 8'd0 : phase_inc[7:0];
               end
               if (emit) begin
                  state_in = ST_RUN;
                  step_in  = '0;
               end
            end
         end
         ST_RUN: begin
            if (step_last) begin
               step_in  = '0;
               state_in = ST_DRAIN;
            end else begin
               step_in = step_ff + SW'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = mac_result;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         fill_ff      <= '0;
         phase_ff     <= '0;
         dec_ff       <= 9'd1;
         taps_ff      <= NW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         fill_ff      <= fill_in;
         phase_ff     <= phase_in;
         dec_ff       <= dec_in;
         taps_ff      <= taps_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_data_ff;

`ifndef SYNTHESIS
   // fill count saturates at the row length
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= NW'(MAX_TAPS))
      else $error("fill count beyond row length");

   // after a windowed sample the phase sits inside the decimation period
   a_phase_wrap: assert property (@(posedge clock) disable iff (reset)
      (sample_fire && window_full) |=> ({1'b0, phase_ff} < dec_ff))
      else $error("decimation phase out of period");

   // step counter only moves while the ring rotates
   a_step_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_RUN) |-> (step_ff == '0))
      else $error("step counter active outside rotation");

   // a full rotation is followed by the drain cycle
   a_run_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && step_last) |=> (state_ff == ST_DRAIN))
      else $error("rotation did not end in drain");
`endif

endmodule

### rtl/cfd_cell.sv
// One cell of the filter row: a history entry, its coefficient and a working
// coefficient that walks towards the head of the row. Depends on cfd_pkg.
module cfd_cell (
   input  logic                                   clock,
   input  logic                                   reset,
   input  cfd_pkg::cell_ctl_type                  ctl,
   input  logic                                   tap_wr,
   input  logic signed [cfd_pkg::SAMPLE_BITS-1:0] tap_wdata,
   input  cfd_pkg::sample_type                    hist_in,
   input  logic signed [cfd_pkg::SAMPLE_BITS-1:0] tapw_in,
   output cfd_pkg::sample_type                    hist_out,
   output logic signed [cfd_pkg::SAMPLE_BITS-1:0] tapw_out
);
   import cfd_pkg::*;

   sample_type                    hist_ff, hist_in_d;
   logic signed [SAMPLE_BITS-1:0] tap_ff, tap_in;
   logic signed [SAMPLE_BITS-1:0] tapw_ff, tapw_in_d;

   // next values: history shifts or rotates, coefficient written by request, working coefficient loaded or shifted
   always_comb begin
      hist_in_d = ctl.shift_hist ? hist_in : hist_ff;
      tap_in    = tap_wr ? tap_wdata : tap_ff;
      if (ctl.load_taps) begin
         tapw_in_d = tap_ff;
      end else if (ctl.shift_taps) begin
         tapw_in_d = tapw_in;
      end else begin
         tapw_in_d = tapw_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= '0;
         tap_ff  <= '0;
      end else begin
         hist_ff <= hist_in_d;
         tap_ff  <= tap_in;
      end
      tapw_ff <= tapw_in_d;
   end

   assign hist_out = hist_ff;
   assign tapw_out = tapw_ff;

endmodule

### rtl/cfd_mac.sv
// Complex multiply-accumulate at the head of the cell row, with rounding and
// saturation of the final sums. Depends on cfd_pkg.
module cfd_mac #(
   parameter int ACC_BITS = 40
) (
   input  logic                                   clock,
   input  cfd_pkg::mac_ctl_type                   ctl,
   input  logic signed [cfd_pkg::SAMPLE_BITS-1:0] tap,
   input  cfd_pkg::sample_type                    smp,
   output cfd_pkg::rsp_payload_type               result
);
   import cfd_pkg::*;

   localparam int PW = 2 * SAMPLE_BITS;
   localparam int EW = (ACC_BITS > PW) ? ACC_BITS : PW;
   localparam int QW = ACC_BITS + 1;
   localparam int SMAX = (1 << (SAMPLE_BITS - 1)) - 1;

   logic signed [PW-1:0]       mult_i, mult_q;
   logic signed [PW-1:0]       prod_i_ff, prod_q_ff, prod_i_in, prod_q_in;
   logic signed [EW-1:0]       ext_i, ext_q;
   logic signed [ACC_BITS-1:0] acc_i_ff, acc_q_ff, acc_i_in, acc_q_in;
   logic [SAMPLE_BITS:0]       fin_i, fin_q;

   // round half up by FRAC_BITS, saturate; msb of the result is the clip flag
   function automatic logic [SAMPLE_BITS:0] finish(input logic signed [ACC_BITS-1:0] acc);
      logic signed [ACC_BITS-1:0] sr;
      logic signed [QW-1:0]       q;
      logic signed [QW-1:0]       hi;
      logic signed [QW-1:0]       lo;
      logic [SAMPLE_BITS:0]       res;
      sr = acc >>> FRAC_BITS;
      q  = QW'(sr) + QW'(acc[FRAC_BITS-1]);
      hi = QW'(SMAX);
      lo = QW'(-SMAX - 1);
      if (q > hi) begin
         res = {1'b1, SAMPLE_BITS'(SMAX)};
      end else if (q < lo) begin
         res = {1'b1, SAMPLE_BITS'(-SMAX - 1)};
      end else begin
         res = {1'b0, q[SAMPLE_BITS-1:0]};
      end
      return res;
   endfunction

   // product stage
   assign mult_i    = $signed(tap) * $signed(smp.i);
   assign mult_q    = $signed(tap) * $signed(smp.q);
   assign prod_i_in = ctl.gate ? mult_i : '0;
   assign prod_q_in = ctl.gate ? mult_q : '0;

   // accumulate stage, wraps modulo 2^ACC_BITS
   assign ext_i    = EW'(prod_i_ff);
   assign ext_q    = EW'(prod_q_ff);
   assign acc_i_in = ctl.clear ? '0 : acc_i_ff + ext_i[ACC_BITS-1:0];
   assign acc_q_in = ctl.clear ? '0 : acc_q_ff + ext_q[ACC_BITS-1:0];

   always_ff @(posedge clock) begin
      prod_i_ff <= prod_i_in;
      prod_q_ff <= prod_q_in;
      acc_i_ff  <= acc_i_in;
      acc_q_ff  <= acc_q_in;
   end

   // final rounding of both components
   assign fin_i = finish(acc_i_ff);
   assign fin_q = finish(acc_q_ff);

   assign result.out_i     = fin_i[SAMPLE_BITS-1:0];
   assign result.out_q     = fin_q[SAMPLE_BITS-1:0];
   assign result.saturated = fin_i[SAMPLE_BITS] | fin_q[SAMPLE_BITS];

endmodule

### verif/complex_decimating_fir_top_test.sv
// Self-checking testbench for the complex decimating FIR filter top level.
// Needs cfd_pkg, cfd_stream_if and the RTL of complex_decimating_fir_top.
`timescale 1ns / 100ps

module complex_decimating_fir_top_test;
   import cfd_pkg::*;

   localparam int MAX_TAPS    = 64;
   localparam int ACC_BITS    = 40;
   localparam int HALF_PERIOD = 5;
   localparam int IDLE_PCT    = 13;
   localparam int SETTLE      = MAX_TAPS + 6;
   localparam longint TIMEOUT_NS = 64'd5_000_000;
   localparam longint SAT_HI  = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
   localparam longint SAT_LO  = -SAT_HI - 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED = 2'd2;

   typedef struct {
      logic                   func;
      logic [SAMPLE_BITS-1:0] sample_i;
      logic [SAMPLE_BITS-1:0] sample_q;
      logic [5:0]             tap_index;
      logic [SAMPLE_BITS-1:0] tap_value;
      bit                     known;
      logic [SAMPLE_BITS-1:0] out_i;
      logic [SAMPLE_BITS-1:0] out_q;
      logic                   saturated;
   } directed_row_type;

   typedef struct {
      int decim;
      int taps;
      int items;
      bit steady;
   } phase_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   steady = 1'b0;
   int   mismatch_count = 0;

   cfd_stream_if #(.payload_type(req_payload_type)) req_ch ();
   cfd_stream_if #(.payload_type(rsp_payload_type)) rsp_ch ();
   cfd_stream_if #(.payload_type(csr_payload_type)) csr_ch ();

   complex_decimating_fir_top #(
      .MAX_TAPS(MAX_TAPS),
      .ACC_BITS(ACC_BITS)
   ) DUT (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   // filter state as the block should hold it
   logic signed [SAMPLE_BITS-1:0] hist_i [MAX_TAPS];
   logic signed [SAMPLE_BITS-1:0] hist_q [MAX_TAPS];
   logic signed [SAMPLE_BITS-1:0] coeffs [MAX_TAPS];
   int                            fill_count = 0;
   int                            decim_count = 0;
   logic [8:0]                    decim_reg = 9'd1;
   logic [6:0]                    taps_reg = 7'd1;

   rsp_payload_type expected_outputs[$];

   // directed requests; typed results where they follow at a glance
   directed_row_type directed_rows [0:15] = '{
      '{FUNC_SAMPLE,    16'h7FFF, 16'h8000, 6'h3F, 16'h7FFF, 1, 16'h0000, 16'h0000, 1'b0},
      '{FUNC_TAP_WRITE, 16'h1234, 16'h5678, 6'h00, 16'h7FFF, 0, 16'h0000, 16'h0000, 1'b0},
      '{FUNC_SAMPLE,    16'h7FFF, 16'h8000, 6'h00, 16'h0000, 1, 16'h7FFE, 16'h8001, 1'b0},
      '{FUNC_TAP_WRITE, 16'hFFFF, 16'hFFFF, 6'h00, 16'h8000, 0, 16'h0000, 16'h0000, 1'b0},
      '{FUNC_SAMPLE,    16'h8000, 16'h8000, 6'h00, 16'h0000, 1, 16'h7FFF, 16'h7FFF, 1'b1},
      '{FUNC_SAMPLE,    16'h7FFF, 16'h0000, 6'h15, 16'hFFFF, 1, 16'h8001, 16'h0000, 1'b0},
      '{FUNC_SAMPLE,    16'h0001, 16'hFFFF, 6'h00, 16'h0000, 1, 16'hFFFF, 16'h0001, 1'b0},
      '{FUNC_TAP_WRITE, 16'h0000, 16'h0000, 6'h00, 16'h4000, 0, 16'h0000, 16'h0000, 1'b0},
      '{FUNC_SAMPLE,    16'h0001, 16'hFFFF, 6'h00, 16'h0000, 1, 16'h0001, 16'h0000, 1'b0},
      '{FUNC_SAMPLE,    16'h0003, 16'hFFFD, 6'h00, 16'h0000, 1, 16'h0002, 16'hFFFF, 1'b0},
      '{FUNC_SAMPLE,    16'h0000, 16'h0000, 6'h3F, 16'h7FFF, 1, 16'h0000, 16'h0000, 1'b0},
      '{FUNC_TAP_WRITE, 16'h7FFF, 16'h8000, 6'h3F, 16'h7FFF, 0, 16'h0000, 16'h0000, 1'b0},
      '{FUNC_TAP_WRITE, 16'h0000, 16'h0000, 6'h01, 16'h8000, 0, 16'h0000, 16'h0000, 1'b0},
      '{FUNC_TAP_WRITE, 16'h0000, 16'h0000, 6'h3F, 16'h8000, 0, 16'h0000, 16'h0000, 1'b0},
      '{FUNC_SAMPLE,    16'h4000, 16'hC000, 6'h00, 16'h0000, 0, 16'h0000, 16'h0000, 1'b0},
      '{FUNC_SAMPLE,    16'hFFFF, 16'h0001, 6'h2A, 16'h5555, 0, 16'h0000, 16'h0000, 1'b0}
   };

   // fixed configurations, extremes and out-of-range codes among them
   phase_type fixed_phases [0:5] = '{
      '{1,   64,  100, 1},
      '{256, 2,   300, 0},
      '{0,   0,   60,  0},
      '{511, 127, 60,  0},
      '{2,   8,   80,  0},
      '{5,   33,  80,  0}
   };

   // clock
   always #HALF_PERIOD clock = ~clock;

   // wrap to accumulator width, round half up, saturate
   function automatic logic signed [SAMPLE_BITS-1:0] round_saturate(input longint sum,
                                                                    inout bit clip);
      logic signed [ACC_BITS-1:0] acc;
      longint                     value;
      acc   = sum[ACC_BITS-1:0];
      value = (longint'(acc) >>> FRAC_BITS) + longint'(acc[FRAC_BITS-1]);
      if (value > SAT_HI) begin
         clip = 1'b1;
         return SAT_HI[SAMPLE_BITS-1:0];
      end
      if (value < SAT_LO) begin
         clip = 1'b1;
         return SAT_LO[SAMPLE_BITS-1:0];
      end
      return value[SAMPLE_BITS-1:0];
   endfunction

   // advance the filter state by one request; returns 1 when an output is due
   function automatic bit filter_step(input req_payload_type item, output rsp_payload_type out);
      int     decim;
      int     taps;
      bit     emit;
      bit     clip;
      longint sum_i;
      longint sum_q;
      out   = '0;
      clip  = 1'b0;
      sum_i = 0;
      sum_q = 0;
      if (item.func == FUNC_TAP_WRITE) begin
         coeffs[item.tap_index] = item.tap_value;
         return 1'b0;
      end
      for (int k = MAX_TAPS - 1; k > 0; k--) begin
         hist_i[k] = hist_i[k-1];
         hist_q[k] = hist_q[k-1];
      end
      hist_i[0] = item.sample_i;
      hist_q[0] = item.sample_q;
      if (fill_count < MAX_TAPS)
         fill_count++;
      decim = (decim_reg == 0) ? 1 : ((decim_reg > 256) ? 256 : int'(decim_reg));
      taps  = (taps_reg == 0) ? 1 : ((taps_reg > MAX_TAPS) ? MAX_TAPS : int'(taps_reg));
      if (fill_count < taps)
         return 1'b0;
      // phase keeps running across register changes
      emit        = (decim_count == 0);
      decim_count = (decim_count + 1 >= decim) ? 0 : decim_count + 1;
      if (!emit)
         return 1'b0;
      // tap 0 meets the oldest sample of the window
      for (int k = 0; k < taps; k++) begin
         sum_i += longint'(coeffs[k]) * longint'(hist_i[taps-1-k]);
         sum_q += longint'(coeffs[k]) * longint'(hist_q[taps-1-k]);
      end
      out.out_i     = round_saturate(sum_i, clip);
      out.out_q     = round_saturate(sum_q, clip);
      out.saturated = clip;
      return 1'b1;
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] random_word();
      case ($urandom_range(7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'($urandom_range(31)) - 16'd16;
         default: return 16'($urandom);
      endcase
   endfunction

   // mostly samples, with coefficient writes mixed in; unused fields carry noise
   function automatic req_payload_type random_request();
      req_payload_type item;
      item.func      = ($urandom_range(99) < 15) ? FUNC_TAP_WRITE : FUNC_SAMPLE;
      item.sample_i  = random_word();
      item.sample_q  = random_word();
      item.tap_index = 6'($urandom_range(63));
      item.tap_value = random_word();
      return item;
   endfunction

   // present one request from a falling edge; returns at a falling edge
   task automatic send_request(input req_payload_type item, input bit known,
                               input rsp_payload_type typed);
      rsp_payload_type predicted;
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= item;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      if (filter_step(item, predicted))
         expected_outputs.push_back(known ? typed : predicted);
      @(negedge clock);
   endtask

   // one configuration write from a falling edge; returns at a falling edge
   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] index,
                                 input logic [CSR_DATA_BITS-1:0] data);
      csr_payload_type write;
      write.index = index;
      write.data  = data;
      csr_ch.valid   <= 1'b1;
      csr_ch.payload <= write;
      @(posedge clock);
      while (!csr_ch.ready)
         @(posedge clock);
      if (index == CSR_DECIMATION)
         decim_reg = data[8:0];
      else if (index == CSR_TAPS_IN_USE)
         taps_reg = data[6:0];
      @(negedge clock);
   endtask

   // let every output arrive, then give the block time to settle
   task automatic wait_drained();
      while (expected_outputs.size() != 0)
         @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic run_phase(input phase_type phase, input bit poke_unused);
      write_register(CSR_DECIMATION, CSR_DATA_BITS'(phase.decim));
      write_register(CSR_TAPS_IN_USE, CSR_DATA_BITS'(phase.taps));
      if (poke_unused)
         write_register(CSR_UNUSED, CSR_DATA_BITS'($urandom));
      csr_ch.valid <= 1'b0;
      steady = phase.steady;
      for (int n = 0; n < phase.items; n++)
         send_request(random_request(), 1'b0, '0);
      req_ch.valid <= 1'b0;
      steady = 1'b0;
      wait_drained();
   endtask

   // result side: random back-pressure, none while steady
   always @(negedge clock)
      rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);

   // compare each output with the oldest outstanding one
   always @(posedge clock) begin
      rsp_payload_type want;
      rsp_payload_type got;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         got = rsp_ch.payload;
         if (expected_outputs.size() == 0) begin
            $error("output with none outstanding: out_i %0d out_q %0d saturated %0d",
                   got.out_i, got.out_q, got.saturated);
            mismatch_count++;
         end else begin
            want = expected_outputs.pop_front();
            if (got.out_i !== want.out_i) begin
               $error("out_i: expected %0d, got %0d", want.out_i, got.out_i);
               mismatch_count++;
            end
            if (got.out_q !== want.out_q) begin
               $error("out_q: expected %0d, got %0d", want.out_q, got.out_q);
               mismatch_count++;
            end
            if (got.saturated !== want.saturated) begin
               $error("saturated: expected %0d, got %0d", want.saturated, got.saturated);
               mismatch_count++;
            end
         end
      end
   end

   // stimulus sequence
   initial begin
      req_payload_type item;
      rsp_payload_type typed;
      phase_type       phase;
      for (int k = 0; k < MAX_TAPS; k++) begin
         hist_i[k] = '0;
         hist_q[k] = '0;
         coeffs[k] = '0;
      end
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      csr_ch.valid   = 1'b0;
      csr_ch.payload = '0;
      rsp_ch.ready   = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part at the reset configuration
      foreach (directed_rows[r]) begin
         item.func       = directed_rows[r].func;
         item.sample_i   = directed_rows[r].sample_i;
         item.sample_q   = directed_rows[r].sample_q;
         item.tap_index  = directed_rows[r].tap_index;
         item.tap_value  = directed_rows[r].tap_value;
         typed.out_i     = directed_rows[r].out_i;
         typed.out_q     = directed_rows[r].out_q;
         typed.saturated = directed_rows[r].saturated;
         send_request(item, directed_rows[r].known, typed);
      end
      req_ch.valid <= 1'b0;
      wait_drained();

      // random part over a range of configurations
      foreach (fixed_phases[p])
         run_phase(fixed_phases[p], p == 2);
      for (int p = 0; p < 5; p++) begin
         phase.decim  = $urandom_range(1, 12);
         phase.taps   = $urandom_range(1, MAX_TAPS);
         phase.items  = 12;
         phase.steady = 1'b0;
         run_phase(phase, 1'b0);
      end

      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // watchdog
   initial begin
      #(TIMEOUT_NS);
      $display("simulation failed");
      $finish;
   end

endmodule
